[rtl/bar_level_peak_hold_meter_assert.svh]
// ---------------------------------------------------------------------------
// bar level meter assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef BAR_LEVEL_PEAK_HOLD_METER_ASSERT_SVH
`define BAR_LEVEL_PEAK_HOLD_METER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define BLPHM_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// next-cycle implication
`define BLPHM_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`else
`define BLPHM_ASSERT_IMP(label, cond, prop, msg)
`define BLPHM_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

[rtl/blphm_pkg.sv]
// ---------------------------------------------------------------------------
// blphm_pkg
// shared types and constants of the bar level peak hold meter
// ---------------------------------------------------------------------------
`default_nettype none

package blphm_pkg;

  localparam int LEVEL_W = 16;
  localparam int HOLD_W  = 6;
  localparam int BAR_W   = 5;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_MARGIN  = 3'd4;

  // register reset values
  localparam logic [LEVEL_W-1:0] RST_ATTACK_COEF = 16'd56667;
  localparam logic [LEVEL_W-1:0] RST_DECAY_COEF  = 16'd27089;
  localparam logic [HOLD_W-1:0]  RST_HOLD_TICKS  = 6'd14;
  localparam logic [LEVEL_W-1:0] RST_FALL_STEP   = 16'd1201;
  localparam logic [LEVEL_W-1:0] RST_ACT_MARGIN  = 16'd66;

  // item modes
  localparam logic MODE_STEP = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  typedef struct packed {
    logic [LEVEL_W-1:0] attack_coef;
    logic [LEVEL_W-1:0] decay_coef;
    logic [HOLD_W-1:0]  hold_ticks;
    logic [LEVEL_W-1:0] fall_step;
    logic [LEVEL_W-1:0] activity_margin;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] body;
    logic [LEVEL_W-1:0] peak;
    logic [HOLD_W-1:0]  hold;
  } bar_state_t;

  typedef struct packed {
    logic               en;
    logic [BAR_W-1:0]   bar;
    bar_state_t         st;
  } wr_req_t;

  typedef struct packed {
    logic [BAR_W-1:0]   bar_number;
    logic [LEVEL_W-1:0] body_level;
    logic [LEVEL_W-1:0] peak_level;
    logic               active;
  } result_t;

endpackage

`default_nettype wire

[rtl/blphm_if.sv]
// ---------------------------------------------------------------------------
// blphm_if
// valid/ready channels for target levels in and bar results out
// ---------------------------------------------------------------------------
`default_nettype none

interface blphm_in_if
  import blphm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [BAR_W-1:0]   bar_index;
  logic [LEVEL_W-1:0] target_level;

  modport source (output valid, output mode, output bar_index, output target_level,
                  input ready);
  modport sink   (input valid, input mode, input bar_index, input target_level,
                  output ready);
endinterface

interface blphm_out_if
  import blphm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [BAR_W-1:0]   bar_number;
  logic [LEVEL_W-1:0] body_level;
  logic [LEVEL_W-1:0] peak_level;
  logic               active;

  modport source (output valid, output bar_number, output body_level, output peak_level,
                  output active, input ready);
  modport sink   (input valid, input bar_number, input body_level, input peak_level,
                  input active, output ready);
endinterface

`default_nettype wire

[rtl/bar_level_peak_hold_meter.sv]
// ---------------------------------------------------------------------------
// bar_level_peak_hold_meter
// per-bar eased level meter with peak cap hold and fall
// ---------------------------------------------------------------------------
// Each transfer on in_item updates one bar: in step mode the body level eases
// toward target_level by the attack or decay fraction, and the peak cap
// follows it up, holds for hold_ticks transfers of that bar, then falls by
// fall_step per transfer without dropping below the body; load mode sets body
// and peak to the target and clears the hold. Every input transfer gives one
// result transfer on out_item, in order. The block takes one item per clock
// while out_item is not stalled; an item for the same bar as the item directly
// ahead of it waits until that item has left stage b, because the bar state
// lives in one memory and the update needs that item's write-back (read at
// accept, multiply, update and write, so the read-modify-write loop spans two
// stages). Bars at or above NUM_BARS leave the state alone and report zero
// levels. The state memory needs no clearing pass: a valid bit per bar makes a
// bar read as zero until its first write. Configuration registers are written
// through cfg_we/cfg_index/cfg_wdata while no item is in flight; the user must
// keep to this, as the block itself does not enforce it.
// ---------------------------------------------------------------------------
`default_nettype none

module bar_level_peak_hold_meter
  import blphm_pkg::*;
#(
  parameter int NUM_BARS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEVEL_W-1:0]   cfg_wdata,
  blphm_in_if.sink                  in_item,
  blphm_out_if.source               out_item
);

  `include "bar_level_peak_hold_meter_assert.svh"

  // configuration registers
  cfg_t cfg_r;

  // stage a: item waiting on its memory read
  logic               a_v_r;
  logic               a_mode_r;
  logic [BAR_W-1:0]   a_bar_r;
  logic [LEVEL_W-1:0] a_target_r;
  logic               a_inr;

  // stage b valid and output register
  logic               b_v_r;
  logic               out_v_r;
  logic               out_v_nxt;
  result_t            out_res_r;

  // handshake
  logic               in_fire;
  logic               out_free;
  logic               b_go;
  logic               b_free;
  logic               hazard;
  logic               a_go;
  logic               a_free;

  // datapath links
  bar_state_t         a_state;
  logic [BAR_W-1:0]   b_bar;
  logic               b_inr;
  bar_state_t         b_state_nxt;
  result_t            b_result;
  wr_req_t            wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_coef     <= RST_ATTACK_COEF;
      cfg_r.decay_coef      <= RST_DECAY_COEF;
      cfg_r.hold_ticks      <= RST_HOLD_TICKS;
      cfg_r.fall_step       <= RST_FALL_STEP;
      cfg_r.activity_margin <= RST_ACT_MARGIN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK_COEF: cfg_r.attack_coef     <= cfg_wdata;
        CFG_DECAY_COEF:  cfg_r.decay_coef      <= cfg_wdata;
        CFG_HOLD_TICKS:  cfg_r.hold_ticks      <= cfg_wdata[HOLD_W-1:0];
        CFG_FALL_STEP:   cfg_r.fall_step       <= cfg_wdata;
        CFG_ACT_MARGIN:  cfg_r.activity_margin <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline flow: each stage moves when the one after it has room
  assign out_free = !out_v_r || out_item.ready;
  assign b_go     = b_v_r && out_free;
  assign b_free   = !b_v_r || b_go;
  // same bar right behind a pending write-back: let b write first
  assign hazard   = a_v_r && b_v_r && a_inr && b_inr && (a_bar_r == b_bar);
  assign a_go     = a_v_r && b_free && !hazard;
  assign a_free   = !a_v_r || a_go;

  assign in_item.ready = a_free;
  assign in_fire       = in_item.valid && a_free;

  // bar range check, widened so any meter size up to 256 compares cleanly
  assign a_inr = {4'd0, a_bar_r} < 9'(NUM_BARS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_v_r <= in_item.valid;
      end
      if (b_free) begin
        b_v_r <= a_go;
      end
    end
  end

  // item payload into stage a on every input transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_mode_r   <= in_item.mode;
      a_bar_r    <= in_item.bar_index;
      a_target_r <= in_item.target_level;
    end
  end

  // write-back as the result leaves stage b
  assign wr.en  = b_go && b_inr;
  assign wr.bar = b_bar;
  assign wr.st  = b_state_nxt;

  blphm_store #(
    .NUM_BARS (NUM_BARS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_bar  (in_item.bar_index),
    .q_bar   (a_bar_r),
    .q_state (a_state),
    .wr      (wr)
  );

  blphm_calc u_calc (
    .clk         (clk),
    .ld          (a_go),
    .a_mode      (a_mode_r),
    .a_bar       (a_bar_r),
    .a_target    (a_target_r),
    .a_inr       (a_inr),
    .a_state     (a_state),
    .cfg         (cfg_r),
    .b_bar       (b_bar),
    .b_inr       (b_inr),
    .b_state_nxt (b_state_nxt),
    .b_result    (b_result)
  );

  // output register parts the result channel from the pipeline
  always_comb begin
    out_v_nxt = out_v_r;
    if (b_go) begin
      out_v_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      out_res_r <= b_result;
    end
  end

  assign out_item.valid      = out_v_r;
  assign out_item.bar_number = out_res_r.bar_number;
  assign out_item.body_level = out_res_r.body_level;
  assign out_item.peak_level = out_res_r.peak_level;
  assign out_item.active     = out_res_r.active;

  // an item never overtakes the pending write-back of its own bar
  `BLPHM_ASSERT_IMP(a_same_bar_waits, hazard, !a_go, "same-bar item left stage a early")
  // a result leaving stage b always lands in the output register
  `BLPHM_ASSERT_NEXT(a_b_to_out, b_go, out_v_r, "stage b result lost")
  // the peak cap never sits below the body
  `BLPHM_ASSERT_IMP(a_peak_above_body, out_v_r,
                    out_res_r.peak_level >= out_res_r.body_level, "peak below body")

endmodule

`default_nettype wire

[rtl/blphm_store.sv]
// ---------------------------------------------------------------------------
// blphm_store
// per-bar state memory with valid bits and write-back forwarding
// ---------------------------------------------------------------------------
`default_nettype none

module blphm_store
  import blphm_pkg::*;
#(
  parameter int NUM_BARS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [BAR_W-1:0] rd_bar,
  input  wire logic [BAR_W-1:0] q_bar,
  output      bar_state_t       q_state,
  input  wire wr_req_t          wr
);

  localparam int AW = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;

  bar_state_t            mem [NUM_BARS];
  bar_state_t            rd_q_r;
  logic [NUM_BARS-1:0]   vld_r;
  wr_req_t               lw0_r;
  wr_req_t               lw1_r;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] q_addr;

  assign rd_addr = AW'(rd_bar);
  assign wr_addr = AW'(wr.bar);
  assign q_addr  = AW'(q_bar);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.st;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // valid bits and the last two writes (en bit is the valid of each)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      lw0_r.en <= 1'b0;
      lw1_r.en <= 1'b0;
    end else if (wr.en) begin
      vld_r[wr_addr] <= 1'b1;
      lw0_r          <= wr;
      lw1_r          <= lw0_r;
    end
  end

  // the read may miss up to two writes that land at or after it
  always_comb begin
    q_state = vld_r[q_addr] ? rd_q_r : '0;
    if (lw1_r.en && (lw1_r.bar == q_bar)) begin
      q_state = lw1_r.st;
    end
    if (lw0_r.en && (lw0_r.bar == q_bar)) begin
      q_state = lw0_r.st;
    end
  end

endmodule

`default_nettype wire

[rtl/blphm_calc.sv]
// ---------------------------------------------------------------------------
// blphm_calc
// easing multiply, then body, peak cap, hold and activity update
// ---------------------------------------------------------------------------
`default_nettype none

module blphm_calc
  import blphm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               ld,
  input  wire logic               a_mode,
  input  wire logic [BAR_W-1:0]   a_bar,
  input  wire logic [LEVEL_W-1:0] a_target,
  input  wire logic               a_inr,
  input  wire bar_state_t         a_state,
  input  wire cfg_t               cfg,
  output      logic [BAR_W-1:0]   b_bar,
  output      logic               b_inr,
  output      bar_state_t         b_state_nxt,
  output      result_t            b_result
);

  // multiply side
  logic               up;
  logic [LEVEL_W-1:0] gap;
  logic [LEVEL_W-1:0] coef;
  logic [31:0]        prod;

  // stage registers
  logic               mode_r;
  logic [BAR_W-1:0]   bar_r;
  logic [LEVEL_W-1:0] target_r;
  logic               inr_r;
  bar_state_t         old_r;
  logic               up_r;
  logic [31:0]        prod_r;

  // update side
  logic [32:0]        rnd;
  logic [LEVEL_W-1:0] step;
  logic [LEVEL_W-1:0] body_n;
  logic [LEVEL_W-1:0] peak_n;
  logic [HOLD_W-1:0]  hold_n;
  logic [LEVEL_W:0]   body_fall;
  logic [LEVEL_W:0]   body_margin;
  logic [LEVEL_W-1:0] diff;
  logic               act;

  assign up   = a_target > a_state.body;
  assign gap  = up ? (a_target - a_state.body) : (a_state.body - a_target);
  assign coef = up ? cfg.attack_coef : cfg.decay_coef;
  assign prod = gap * coef;

  always_ff @(posedge clk) begin
    if (ld) begin
      mode_r   <= a_mode;
      bar_r    <= a_bar;
      target_r <= a_target;
      inr_r    <= a_inr;
      old_r    <= a_state;
      up_r     <= up;
      prod_r   <= prod;
    end
  end

  // rounded step, halves away from zero; never passes the target
  assign rnd  = {1'b0, prod_r} + 33'd32768;
  assign step = rnd[31:16];

  always_comb begin
    body_n    = up_r ? (old_r.body + step) : (old_r.body - step);
    body_fall = {1'b0, body_n} + {1'b0, cfg.fall_step};
    peak_n    = old_r.peak;
    hold_n    = old_r.hold;
    if (mode_r == MODE_LOAD) begin
      body_n = target_r;
      peak_n = target_r;
      hold_n = '0;
    end else if (body_n >= old_r.peak) begin
      peak_n = body_n;
      hold_n = cfg.hold_ticks;
    end else if (old_r.hold != '0) begin
      hold_n = old_r.hold - 6'd1;
    end else begin
      peak_n = ({1'b0, old_r.peak} > body_fall) ? (old_r.peak - cfg.fall_step) : body_n;
    end
  end

  assign body_margin = {1'b0, body_n} + {1'b0, cfg.activity_margin};
  assign diff        = (body_n > target_r) ? (body_n - target_r) : (target_r - body_n);
  assign act         = (body_n > cfg.activity_margin) || ({1'b0, peak_n} > body_margin) ||
                       (diff > cfg.activity_margin);

  assign b_bar            = bar_r;
  assign b_inr            = inr_r;
  assign b_state_nxt.body = body_n;
  assign b_state_nxt.peak = peak_n;
  assign b_state_nxt.hold = hold_n;

  // bars beyond the meter report zeros
  always_comb begin
    b_result.bar_number = bar_r;
    b_result.body_level = inr_r ? body_n : '0;
    b_result.peak_level = inr_r ? peak_n : '0;
    b_result.active     = inr_r && act;
  end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bar level peak hold meter
// Drives per-bar target levels through the valid/ready input channel,
// predicts body, peak, hold and activity for every transfer, and compares
// each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import blphm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BAR_COUNT    = 32;
  localparam int DRAIN_CYCLES = 8;       // margin after the last result comes back
  localparam int CYCLE_LIMIT  = 600000;  // watchdog limit for the whole run

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the bar state and the registers, a queue of
  // predicted results, and a mismatch counter
  // --------------------------------------------------------------------------
  class meter_scoreboard;
    cfg_t               regs;
    logic [LEVEL_W-1:0] body_mem [BAR_COUNT];
    logic [LEVEL_W-1:0] peak_mem [BAR_COUNT];
    logic [HOLD_W-1:0]  hold_mem [BAR_COUNT];
    result_t            pending_results[$];
    int mismatches;
    int inputs_seen;
    int results_seen;
    int loads;
    int attacks;
    int decays;
    int hold_ticks_seen;
    int peak_falls;
    int active_seen;

    function new();
      regs.attack_coef     = RST_ATTACK_COEF;
      regs.decay_coef      = RST_DECAY_COEF;
      regs.hold_ticks      = RST_HOLD_TICKS;
      regs.fall_step       = RST_FALL_STEP;
      regs.activity_margin = RST_ACT_MARGIN;
      for (int i = 0; i < BAR_COUNT; i++) begin
        body_mem[i] = '0;
        peak_mem[i] = '0;
        hold_mem[i] = '0;
      end
      mismatches = 0;
      inputs_seen = 0;
      results_seen = 0;
      loads = 0;
      attacks = 0;
      decays = 0;
      hold_ticks_seen = 0;
      peak_falls = 0;
      active_seen = 0;
    endfunction

    function void report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endfunction

    // writes to unused indexes fall through and change nothing
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
      case (idx)
        CFG_ATTACK_COEF: regs.attack_coef     = val;
        CFG_DECAY_COEF:  regs.decay_coef      = val;
        CFG_HOLD_TICKS:  regs.hold_ticks      = val[HOLD_W-1:0];
        CFG_FALL_STEP:   regs.fall_step       = val;
        CFG_ACT_MARGIN:  regs.activity_margin = val;
        default: ;
      endcase
    endfunction

    // body moves by round(gap * coef / 2^16), halves away from zero
    function logic [LEVEL_W-1:0] eased_level(logic [LEVEL_W-1:0] body,
                                             logic [LEVEL_W-1:0] target);
      longint unsigned gap;
      longint unsigned step;
      if (target > body) begin
        gap  = longint'(target) - longint'(body);
        step = (gap * longint'(regs.attack_coef) + 64'd32768) >> 16;
        attacks++;
        return LEVEL_W'(longint'(body) + step);
      end
      gap  = longint'(body) - longint'(target);
      step = (gap * longint'(regs.decay_coef) + 64'd32768) >> 16;
      decays++;
      return LEVEL_W'(longint'(body) - step);
    endfunction

    function void note_input(logic mode, logic [BAR_W-1:0] bar, logic [LEVEL_W-1:0] target);
      int      b;
      int      p;
      int      t;
      int      m;
      int      gap;
      result_t res;
      logic [LEVEL_W-1:0] body;
      logic [LEVEL_W-1:0] peak;
      logic [HOLD_W-1:0]  hold;
      inputs_seen++;
      if (mode == MODE_LOAD) begin
        body = target;
        peak = target;
        hold = '0;
        loads++;
      end else begin
        body = eased_level(body_mem[bar], target);
        peak = peak_mem[bar];
        hold = hold_mem[bar];
        if (body >= peak) begin
          peak = body;
          hold = regs.hold_ticks;
        end else if (hold != '0) begin
          hold = hold - 1'b1;
          hold_ticks_seen++;
        end else begin
          // fall, but never below the body
          if (int'(peak) > int'(body) + int'(regs.fall_step))
            peak = peak - regs.fall_step;
          else
            peak = body;
          peak_falls++;
        end
      end
      body_mem[bar] = body;
      peak_mem[bar] = peak;
      hold_mem[bar] = hold;

      b = int'(body);
      p = int'(peak);
      t = int'(target);
      m = int'(regs.activity_margin);
      gap = (b > t) ? b - t : t - b;
      res.bar_number = bar;
      res.body_level = body;
      res.peak_level = peak;
      res.active     = (b > m) || (p > b + m) || (gap > m);
      if (res.active) active_seen++;
      pending_results.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("result for bar %0d with nothing outstanding", got.bar_number));
        return;
      end
      want = pending_results.pop_front();
      if (got.bar_number !== want.bar_number)
        report($sformatf("bar_number %0d, predicted %0d", got.bar_number, want.bar_number));
      if (got.body_level !== want.body_level)
        report($sformatf("bar %0d body_level %0d, predicted %0d",
                         want.bar_number, got.body_level, want.body_level));
      if (got.peak_level !== want.peak_level)
        report($sformatf("bar %0d peak_level %0d, predicted %0d",
                         want.bar_number, got.peak_level, want.peak_level));
      if (got.active !== want.active)
        report($sformatf("bar %0d active %0b, predicted %0b",
                         want.bar_number, got.active, want.active));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block itself
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEVEL_W-1:0]   cfg_wdata;

  blphm_in_if  in_bus();
  blphm_out_if out_bus();

  bar_level_peak_hold_meter #(
    .NUM_BARS (BAR_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_bus),
    .out_item  (out_bus)
  );

  always #10 clk = ~clk;

  meter_scoreboard sb = new();

  // when set, neither side idles: stretches of full-rate traffic
  bit no_idle = 1'b0;
  int config_sets = 0;
  int cycle_count = 0;

  // per-bar level that the random traffic hovers around
  logic [LEVEL_W-1:0] plan_level [BAR_COUNT];

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, none at all while no_idle is set
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // result side backpressure, one assignment per clock edge
  initial begin
    int stall;
    stall = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // result monitor, values sampled before this edge's updates
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.bar_number = out_bus.bar_number;
      got.body_level = out_bus.body_level;
      got.peak_level = out_bus.peak_level;
      got.active     = out_bus.active;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // driving tasks
  // --------------------------------------------------------------------------

  // one input transfer; valid stays high into the next item when no gap is drawn
  task automatic send_item(input logic mode, input logic [BAR_W-1:0] bar,
                           input logic [LEVEL_W-1:0] target);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.mode         <= mode;
    in_bus.bar_index    <= bar;
    in_bus.target_level <= target;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_input(mode, bar, target);
  endtask

  // drop valid, let every result come back, then the pipeline tail
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all five registers back to back, then one write to an unused index
  task automatic apply_settings(input cfg_t s);
    logic [CFG_IDX_W-1:0] idx [6];
    logic [LEVEL_W-1:0]   val [6];
    logic [9:0]           junk;
    wait_drained();
    junk   = 10'($urandom);
    idx[0] = CFG_ATTACK_COEF;  val[0] = s.attack_coef;
    idx[1] = CFG_DECAY_COEF;   val[1] = s.decay_coef;
    // upper bits of the hold write are don't-care, drive them random
    idx[2] = CFG_HOLD_TICKS;   val[2] = {junk, s.hold_ticks};
    idx[3] = CFG_FALL_STEP;    val[3] = s.fall_step;
    idx[4] = CFG_ACT_MARGIN;   val[4] = s.activity_margin;
    idx[5] = CFG_IDX_W'(CFG_ACT_MARGIN + $urandom_range(1, 3));
    val[5] = 16'($urandom);
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.write_register(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    config_sets++;
  endtask

  function automatic cfg_t random_settings(bit fast_fall);
    cfg_t s;
    s.attack_coef     = 16'($urandom);
    s.decay_coef      = 16'($urandom);
    s.hold_ticks      = fast_fall ? HOLD_W'($urandom_range(0, 4)) : HOLD_W'($urandom);
    s.fall_step       = fast_fall ? 16'($urandom_range(1, 4000)) : 16'($urandom);
    s.activity_margin = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 2000));
    return s;
  endfunction

  // random traffic: mostly a few focus bars so each one sees long runs of
  // steps (attack, hold countdown, fall), the rest spread over all bars
  task automatic run_random(input int count);
    logic [BAR_W-1:0]   focus [4];
    logic [BAR_W-1:0]   bar;
    logic [LEVEL_W-1:0] target;
    logic               mode;
    int                 r;
    for (int i = 0; i < 4; i++) focus[i] = BAR_W'($urandom_range(0, BAR_COUNT - 1));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 49) == 0) no_idle = ~no_idle;
      if ($urandom_range(0, 99) < 80) bar = focus[$urandom_range(0, 3)];
      else                            bar = BAR_W'($urandom_range(0, BAR_COUNT - 1));
      // occasionally move the level this bar hovers around
      if ($urandom_range(0, 19) == 0) begin
        r = $urandom_range(0, 3);
        plan_level[bar] = (r == 0) ? '0 : (r == 1) ? '1 : 16'($urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 20)      target = '0;
      else if (r < 28) target = '1;
      else if (r < 40) target = 16'($urandom);
      else             target = plan_level[bar] ^ 16'($urandom_range(0, 63));
      mode = ($urandom_range(0, 99) < 7) ? MODE_LOAD : MODE_STEP;
      send_item(mode, bar, target);
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t s;
    in_bus.valid        <= 1'b0;
    in_bus.mode         <= MODE_STEP;
    in_bus.bar_index    <= '0;
    in_bus.target_level <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_ATTACK_COEF;
    cfg_wdata           <= '0;
    for (int i = 0; i < BAR_COUNT; i++) plan_level[i] = 16'($urandom);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset settings
    send_item(MODE_STEP, 5'd0, 16'd0);        // untouched bar, zero in, zero out
    send_item(MODE_STEP, 5'd0, 16'hFFFF);     // full-scale attack
    send_item(MODE_STEP, 5'd0, 16'hFFFF);
    send_item(MODE_LOAD, 5'd31, 16'hFFFF);    // load top bar at full scale
    send_item(MODE_STEP, 5'd31, 16'd0);       // decay with hold cleared: peak falls
    send_item(MODE_STEP, 5'd31, 16'd0);
    send_item(MODE_LOAD, 5'd1, 16'd0);
    send_item(MODE_STEP, 5'd1, 16'd66);       // gap right at the margin
    send_item(MODE_STEP, 5'd1, 16'd67);       // just over the margin
    send_item(MODE_LOAD, 5'd2, 16'd40000);
    send_item(MODE_STEP, 5'd2, 16'd40000);    // body meets peak, hold reloads
    for (int i = 0; i < 12; i++)
      send_item(MODE_STEP, 5'd2, 16'd0);      // body drops, peak held
    send_item(MODE_STEP, 5'd21, 16'h5555);
    send_item(MODE_STEP, 5'd10, 16'hAAAA);

    run_random(240);

    // lower extremes: no easing, no hold, no fall, zero margin
    s = '0;
    apply_settings(s);
    run_random(200);

    // upper extremes
    s.attack_coef     = '1;
    s.decay_coef      = '1;
    s.hold_ticks      = '1;
    s.fall_step       = '1;
    s.activity_margin = '1;
    apply_settings(s);
    run_random(200);

    for (int p = 0; p < 4; p++) begin
      apply_settings(random_settings(p % 2 == 0));
      no_idle = (p == 1);
      run_random(260);
    end
    no_idle = 1'b0;

    wait_drained();

    $display("covered %0d transfers in, %0d results: %0d loads, %0d attack, %0d decay steps",
             sb.inputs_seen, sb.results_seen, sb.loads, sb.attacks, sb.decays);
    $display("  %0d hold ticks, %0d peak falls, %0d active, %0d register sets, %0d mismatches",
             sb.hold_ticks_seen, sb.peak_falls, sb.active_seen, config_sets, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
